/* src/fpdf_pkg.sv */
// Shared types, constants and helpers of the fixed-point decimal formatter.
`timescale 1ns / 1ps
package fpdf_pkg;

   localparam int MAG_WIDTH   = 64;
   localparam int NUM_DIGITS  = 20;
   localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
   localparam int CSR_AWIDTH  = 3;
   localparam int CSR_DWIDTH  = 32;

   localparam logic [4:0] MAX_SCALE         = 5'd18;
   localparam logic [4:0] LAST_NORM_STEP    = 5'd19;
   localparam logic [4:0] FULL_WIDTH_DIGITS = 5'd20;
   localparam logic [5:0] LAST_CONV_STEP    = 6'd63;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   localparam logic REG_STORED_SCALE  = 1'b0;
   localparam logic REG_OUTPUT_DIGITS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_CHECK,
      ST_NORMALISE,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_DABBLE,
      OP_SHIFT_RIGHT,
      OP_SHIFT_LEFT
   } op_type;

   function automatic logic [4:0] clamp_scale(input logic [4:0] value);
      return (value > MAX_SCALE) ? MAX_SCALE : value;
   endfunction

endpackage

/* src/fpdf_req_if.sv */
// Input channel interface carrying one scaled value per word.
`timescale 1ns / 1ps
interface fpdf_req_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] units_value;

   modport source (output valid, output units_value, input ready);
   modport sink (input valid, input units_value, output ready);
endinterface

/* src/fpdf_rsp_if.sv */
// Result channel interface carrying one text character per word.
`timescale 1ns / 1ps
interface fpdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       last_char;
   logic       status;

   modport source (output valid, output text_char, output last_char, output status,
                   input ready);
   modport sink (input valid, input text_char, input last_char, input status,
                 output ready);
endinterface

/* src/fixed_point_decimal_formatter_core.sv */
// Top level of the fixed-point decimal formatter: sequencer, registers and ports.
//
//   Channel   Direction  Carries
//   req_chan  in         units_value, one word per value
//   rsp_chan  out        text_char, last_char, status, one word per character
//   csr_*     in         APB writes and reads of the two format registers
//
// A value is accepted, converted in the shared BCD unit, checked for nonzero dropped
// digits and normalised, then emitted at one cycle per character (up to 39) while
// the result side takes words.
// req_chan.ready is high only in the idle state. The result register is
// reloaded in the cycle it is taken, so an unstalled run emits a word a cycle.
// Reset is synchronous and clears the sequencer, the result valid and both
// registers.
`timescale 1ns / 1ps
module fixed_point_decimal_formatter_core (
   input  logic                            clock,
   input  logic                            reset,
   fpdf_req_if.sink                        req_chan,
   fpdf_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fpdf_pkg::CSR_AWIDTH-1:0] csr_paddr,
   input  logic [fpdf_pkg::CSR_DWIDTH-1:0] csr_pwdata,
   output logic [fpdf_pkg::CSR_DWIDTH-1:0] csr_prdata,
   output logic                            csr_pready
);
   import fpdf_pkg::*;

   state_type   state_ff, state_in;
   op_type      op;
   logic [5:0]  cnt_ff, cnt_in;
   logic [5:0]  pos_ff, pos_in;
   logic        neg_ff, neg_in;
   logic        sign_ff, sign_in;
   logic [4:0]  dc_ff, dc_in;
   logic [4:0]  storage_ff;
   logic [4:0]  output_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic        status_ff, status_in;

   logic [3:0]  top_digit;
   logic [3:0]  low_digit;
   logic [63:0] magnitude;
   logic [4:0]  ss, od, drop, rf, intcnt, ilen, pad;
   logic [5:0]  len, p, q;
   logic        out_free;
   logic        is_last;
   logic [7:0]  emit_char;
   logic        emit_digit;
   logic        csr_write;

   fpdf_bcd_unit u_bcd (
      .clock      (clock),
      .op         (op),
      .load_value (magnitude),
      .top_digit  (top_digit),
      .low_digit  (low_digit)
   );

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DWIDTH-5){1'b0}},
                        (csr_paddr[2] == REG_OUTPUT_DIGITS) ? output_ff : storage_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         storage_ff <= '0;
         output_ff  <= '0;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_STORED_SCALE) begin
            storage_ff <= csr_pwdata[4:0];
         end else begin
            output_ff <= csr_pwdata[4:0];
         end
      end
   end

   assign magnitude = req_chan.units_value[63] ? (~req_chan.units_value + 64'd1)
                                               : req_chan.units_value;

   // Layout figures: rf fraction digits kept, intcnt whole digits of the value.
   always_comb begin
      ss     = clamp_scale(storage_ff);
      od     = clamp_scale(output_ff);
      drop   = (od < ss) ? ss - od : 5'd0;
      rf     = (od < ss) ? od : ss;
      if (rf == 5'd0) begin
         intcnt = dc_ff;
      end else if (dc_ff > rf) begin
         intcnt = dc_ff - rf;
      end else begin
         intcnt = 5'd0;
      end
      ilen   = (intcnt == 5'd0) ? 5'd1 : intcnt;
      pad    = (intcnt == 5'd0 && rf > dc_ff) ? rf - dc_ff : 5'd0;
      len    = {5'd0, sign_ff} + {1'b0, ilen} + {5'd0, (od != 5'd0)} + {1'b0, od};
      is_last = (pos_ff == len - 6'd1);
      p      = pos_ff - {5'd0, sign_ff};
      q      = p - {1'b0, ilen} - 6'd1;
   end

   always_comb begin
      emit_char  = CHAR_ZERO;
      emit_digit = 1'b0;
      if (sign_ff && pos_ff == 6'd0) begin
         emit_char = CHAR_MINUS;
      end else if (p < {1'b0, ilen}) begin
         if (intcnt != 5'd0) begin
            emit_char  = {4'h3, top_digit};
            emit_digit = 1'b1;
         end
      end else if (p == {1'b0, ilen}) begin
         emit_char = CHAR_POINT;
      end else if (q < {1'b0, pad}) begin
         emit_char = CHAR_ZERO;
      end else if (q < {1'b0, rf}) begin
         emit_char  = {4'h3, top_digit};
         emit_digit = 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      op           = OP_HOLD;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      sign_in      = sign_ff;
      dc_in        = dc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op       = OP_LOAD;
               neg_in   = req_chan.units_value[63];
               cnt_in   = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            op     = OP_DABBLE;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LAST_CONV_STEP) begin
               cnt_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cnt_ff[4:0] == drop) begin
               cnt_in   = '0;
               state_in = ST_NORMALISE;
            end else if (low_digit != 4'h0) begin
               state_in = ST_ERROR;
            end else begin
               op     = OP_SHIFT_RIGHT;
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_NORMALISE: begin
            if (top_digit != 4'h0 || cnt_ff[4:0] == LAST_NORM_STEP) begin
               dc_in    = FULL_WIDTH_DIGITS - cnt_ff[4:0];
               sign_in  = neg_ff && (top_digit != 4'h0);
               pos_in   = '0;
               state_in = ST_EMIT;
            end else begin
               op     = OP_SHIFT_LEFT;
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = emit_char;
               last_in      = is_last;
               status_in    = 1'b0;
               pos_in       = pos_ff + 6'd1;
               if (emit_digit) begin
                  op = OP_SHIFT_LEFT;
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CHAR_NONE;
               last_in      = 1'b1;
               status_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      sign_ff   <= sign_in;
      dc_ff     <= dc_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.text_char = char_ff;
   assign rsp_chan.last_char = last_ff;
   assign rsp_chan.status    = status_ff;

endmodule

/* src/fpdf_bcd_unit.sv */
// Shared BCD datapath: binary to BCD conversion and decimal digit shifts.
`timescale 1ns / 1ps
module fpdf_bcd_unit (
   input  logic                      clock,
   input  fpdf_pkg::op_type          op,
   input  logic [63:0]               load_value,
   output logic [3:0]                top_digit,
   output logic [3:0]                low_digit
);
   import fpdf_pkg::*;

   logic [MAG_WIDTH-1:0] bin_ff;
   logic [MAG_WIDTH-1:0] bin_in;
   logic [BCD_WIDTH-1:0] bcd_ff;
   logic [BCD_WIDTH-1:0] bcd_in;
   logic [BCD_WIDTH-1:0] adjusted;

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adjusted[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            adjusted[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      unique case (op)
         OP_HOLD: begin
         end
         OP_LOAD: begin
            bin_in = load_value;
            bcd_in = '0;
         end
         OP_DABBLE: begin
            bcd_in = {adjusted[BCD_WIDTH-2:0], bin_ff[MAG_WIDTH-1]};
            bin_in = {bin_ff[MAG_WIDTH-2:0], 1'b0};
         end
         OP_SHIFT_RIGHT: begin
            bcd_in = {4'h0, bcd_ff[BCD_WIDTH-1:4]};
         end
         OP_SHIFT_LEFT: begin
            bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'h0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];
   assign low_digit = bcd_ff[3:0];

endmodule
